// ===== design/hsl_pkg.sv =====
package hsl_pkg;

   localparam int SIG_WORDS        = 4;
   localparam int IDX_W            = 2;
   localparam int POOL_MAX         = 16;
   localparam int SLOT_W           = 4;
   localparam int CNT_W            = 5;
   localparam int DIST_W           = 9;
   localparam int DIST_MAX         = 511;
   localparam int ID_W             = 40;
   localparam int WORD_W           = 64;
   localparam int BYTES_W          = WORD_W / 8;
   localparam int BCNT_W           = 4;
   localparam int PCNT_W           = 7;
   localparam int KIND_W           = 2;
   localparam int REQ_TDATA_W      = 112;
   localparam int RSP_TDATA_W      = 56;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QPTR_W           = 2;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;
   localparam int KEEP_LIMIT_RESET = 16;

   localparam logic CSR_KEEP_LIMIT = 1'b0;

   typedef enum logic [KIND_W-1:0] {
      KIND_QUERY  = 2'd0,
      KIND_CAND   = 2'd1,
      KIND_FINISH = 2'd2
   } hsl_kind_type;

   typedef enum logic {
      OP_OFFER  = 1'b0,
      OP_FINISH = 1'b1
   } hsl_op_type;

   typedef struct packed {
      hsl_op_type        op;
      logic [ID_W-1:0]   doc_id;
      logic [DIST_W-1:0] distance;
   } hsl_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SEARCH = 2'd1,
      ST_EMIT   = 2'd2
   } hsl_state_type;

endpackage

// ===== design/hsl_front.sv =====
module hsl_front
   import hsl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // word, word_index, doc_id, doc_present, doc_deleted, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // kind
   input  logic [KIND_W-1:0]      req_tuser,
   input  logic                   req_tlast,
   output logic                   q_push,
   output hsl_cmd_type            q_data,
   input  logic                   q_full
);

   logic [WORD_W-1:0] query_ff [SIG_WORDS];

   logic [WORD_W-1:0] in_word;
   logic [IDX_W-1:0]  in_idx;
   logic [ID_W-1:0]   in_id;
   logic              in_live;
   logic              in_range;
   logic              accept;
   logic              capture;
   logic [WORD_W-1:0] diff;
   logic [BCNT_W-1:0] bc [BYTES_W];

   logic              s_valid_ff, s_valid_in;
   logic              s_fin_ff;
   logic              s_en_ff;
   logic              s_last_ff;
   logic              s_live_ff;
   logic [ID_W-1:0]   s_id_ff;
   logic [BCNT_W-1:0] s_bc_ff [BYTES_W];

   logic [DIST_W-1:0] acc_ff, acc_in;
   logic [PCNT_W-1:0] pc;
   logic [DIST_W:0]   sum;
   logic [DIST_W-1:0] dist_new;
   logic              need_push;
   logic              go;

   assign in_word  = req_tdata[WORD_W-1:0];
   assign in_idx   = req_tdata[WORD_W+IDX_W-1:WORD_W];
   assign in_id    = req_tdata[WORD_W+IDX_W+ID_W-1:WORD_W+IDX_W];
   assign in_live  = req_tdata[WORD_W+IDX_W+ID_W] && !req_tdata[WORD_W+IDX_W+ID_W+1];
   assign in_range = 32'(in_idx) < SIG_WORDS;

   assign accept  = req_tvalid && req_tready;
   assign capture = accept && (req_tuser == KIND_CAND || req_tuser == KIND_FINISH);

   assign diff = in_word ^ query_ff[in_idx];

   // per-byte bit counts, summed in the stage after
   always_comb begin
      for (int b = 0; b < BYTES_W; b++) begin
         bc[b] = '0;
         for (int j = 0; j < 8; j++) begin
            bc[b] = bc[b] + BCNT_W'(diff[8*b+j]);
         end
      end
   end

   always_comb begin
      pc = '0;
      for (int b = 0; b < BYTES_W; b++) begin
         pc = pc + PCNT_W'(s_bc_ff[b]);
      end
   end

   assign sum      = (DIST_W+1)'(acc_ff) + (s_en_ff ? (DIST_W+1)'(pc) : '0);
   assign dist_new = (sum > (DIST_W+1)'(DIST_MAX)) ? DIST_W'(DIST_MAX) : sum[DIST_W-1:0];

   assign need_push = s_fin_ff || (s_last_ff && s_live_ff);
   assign go        = s_valid_ff && !(need_push && q_full);
   assign q_push    = s_valid_ff && need_push && !q_full;
   assign req_tready = !s_valid_ff || go;

   always_comb begin
      q_data.op       = s_fin_ff ? OP_FINISH : OP_OFFER;
      q_data.doc_id   = s_id_ff;
      q_data.distance = dist_new;
   end

   always_comb begin
      acc_in = acc_ff;
      if (go) begin
         if (s_fin_ff || s_last_ff) begin
            acc_in = '0;
         end else begin
            acc_in = dist_new;
         end
      end
   end

   always_comb begin
      s_valid_in = s_valid_ff;
      if (capture) begin
         s_valid_in = 1'b1;
      end else if (go) begin
         s_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
         acc_ff     <= '0;
      end else begin
         s_valid_ff <= s_valid_in;
         acc_ff     <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_tuser == KIND_QUERY && in_range) begin
         query_ff[in_idx] <= in_word;
      end
      if (capture) begin
         s_fin_ff  <= (req_tuser == KIND_FINISH);
         s_en_ff   <= (req_tuser == KIND_CAND) && in_live && in_range;
         s_last_ff <= req_tlast;
         s_live_ff <= in_live;
         s_id_ff   <= in_id;
         s_bc_ff   <= bc;
      end
   end

endmodule

// ===== design/hsl_fifo.sv =====
module hsl_fifo
   import hsl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  hsl_cmd_type push_data,
   output logic        full,
   input  logic        pop,
   output hsl_cmd_type pop_data,
   output logic        empty
);

   hsl_cmd_type       entries_ff [QUEUE_DEPTH];
   logic [QPTR_W:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W:0]   rd_ptr_ff, rd_ptr_in;

   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full  = (wr_ptr_ff[QPTR_W] != rd_ptr_ff[QPTR_W]) &&
                  (wr_ptr_ff[QPTR_W-1:0] == rd_ptr_ff[QPTR_W-1:0]);
   assign pop_data = entries_ff[rd_ptr_ff[QPTR_W-1:0]];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff[QPTR_W-1:0]] <= push_data;
      end
   end

`ifndef SYNTH
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("pop from empty queue");
`endif

endmodule

// ===== design/hsl_back.sv =====
module hsl_back
   import hsl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [CNT_W-1:0]       keep_limit,
   input  logic                   q_empty,
   input  hsl_cmd_type            q_data,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // slot_doc_id, slot_distance, pool_count, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // empty_res
   output logic                   rsp_tuser,
   output logic                   rsp_tlast
);

   hsl_state_type     state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]  filled_ff, filled_in;
   logic [CNT_W-1:0]  n_ff;
   logic [ID_W-1:0]   cmd_doc_ff;
   logic [DIST_W-1:0] cmd_dist_ff;
   logic [SLOT_W-1:0] worst_idx_ff;
   logic [DIST_W-1:0] worst_dist_ff;
   logic [ID_W-1:0]   pool_doc_ff  [POOL_MAX];
   logic [DIST_W-1:0] pool_dist_ff [POOL_MAX];

   logic              out_valid_ff, out_valid_in;
   logic [ID_W-1:0]   out_doc_ff;
   logic [DIST_W-1:0] out_dist_ff;
   logic [CNT_W-1:0]  out_cnt_ff;
   logic              out_empty_ff;
   logic              out_last_ff;

   logic [CNT_W-1:0]  active;
   logic [ID_W-1:0]   rd_doc;
   logic [DIST_W-1:0] rd_dist;
   logic              take_new;
   logic [SLOT_W-1:0] cur_worst_idx;
   logic [DIST_W-1:0] cur_worst_dist;
   logic              search_end;
   logic              emit_end;
   logic              out_free;
   logic              fill_we;
   logic              repl_we;
   logic              emit_load;
   logic [SLOT_W-1:0] wr_addr;
   logic [ID_W-1:0]   wr_doc;
   logic [DIST_W-1:0] wr_dist;

   assign active = (keep_limit > CNT_W'(POOL_MAX)) ? CNT_W'(POOL_MAX) : keep_limit;

   assign rd_doc  = pool_doc_ff[idx_ff];
   assign rd_dist = pool_dist_ff[idx_ff];

   assign take_new       = (idx_ff == '0) || (rd_dist > worst_dist_ff);
   assign cur_worst_idx  = take_new ? idx_ff  : worst_idx_ff;
   assign cur_worst_dist = take_new ? rd_dist : worst_dist_ff;
   assign search_end     = ({1'b0, idx_ff} == active - 1'b1);
   assign emit_end       = (n_ff == '0) || ({1'b0, idx_ff} == n_ff - 1'b1);
   assign out_free       = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               if (q_data.op == OP_FINISH) begin
                  state_in = ST_EMIT;
               end else if (active != '0 && filled_ff >= active) begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (search_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free && emit_end) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop     = (state_ff == ST_IDLE) && !q_empty;
      fill_we   = q_pop && (q_data.op == OP_OFFER) && (active != '0) && (filled_ff < active);
      repl_we   = (state_ff == ST_SEARCH) && search_end && (cmd_dist_ff < cur_worst_dist);
      emit_load = (state_ff == ST_EMIT) && out_free;
      wr_addr   = fill_we ? filled_ff[SLOT_W-1:0] : cur_worst_idx;
      wr_doc    = fill_we ? q_data.doc_id   : cmd_doc_ff;
      wr_dist   = fill_we ? q_data.distance : cmd_dist_ff;
   end

   always_comb begin
      idx_in = idx_ff;
      if (q_pop) begin
         idx_in = '0;
      end else if (state_ff == ST_SEARCH && !search_end) begin
         idx_in = idx_ff + 1'b1;
      end else if (emit_load && !emit_end) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      filled_in = filled_ff;
      if (fill_we) begin
         filled_in = filled_ff + 1'b1;
      end else if (emit_load && emit_end) begin
         filled_in = '0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         filled_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filled_ff    <= filled_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (q_pop) begin
         cmd_doc_ff  <= q_data.doc_id;
         cmd_dist_ff <= q_data.distance;
         n_ff        <= filled_ff;
      end
      if (state_ff == ST_SEARCH) begin
         worst_idx_ff  <= cur_worst_idx;
         worst_dist_ff <= cur_worst_dist;
      end
      if (fill_we || repl_we) begin
         pool_doc_ff[wr_addr]  <= wr_doc;
         pool_dist_ff[wr_addr] <= wr_dist;
      end
      if (emit_load) begin
         out_empty_ff <= (n_ff == '0);
         out_doc_ff   <= (n_ff == '0) ? '0 : rd_doc;
         out_dist_ff  <= (n_ff == '0) ? '0 : rd_dist;
         out_cnt_ff   <= n_ff;
         out_last_ff  <= emit_end;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W-ID_W-DIST_W-CNT_W)'(0), out_cnt_ff, out_dist_ff, out_doc_ff};
   assign rsp_tuser  = out_empty_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTH
   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= CNT_W'(POOL_MAX)) else $error("pool fill count beyond pool depth");
   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && out_cnt_ff == '0)
      else $error("empty marker not alone");
   a_entry_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> out_cnt_ff != '0)
      else $error("pool entry with zero count");
`endif

endmodule

// ===== design/hamming_top_k_shortlist_core.sv =====
// hamming shortlist: keeps the nearest documents to a query signature
// req channel: kind in tuser (query word, candidate word, finish),
//   word, word index, doc id and presence flags in tdata, last word in tlast
// rsp channel: one transfer per filled pool slot at finish, slot order,
//   or a single empty marker (tuser high); tlast on the final one
// csr port: register 0 is the keep limit, written on the apb access cycle
// front: one request per cycle; bit counts of the xor are taken on accept,
//   summed into the running distance the cycle after
// back: a pool entry is filled at queue pop; a replacement scans the pool
//   one slot per cycle over the active slots once the pool is full
// a candidate word that is not last never waits on the back half, and a last word
//   waits only once the 4-entry queue between the two halves fills
// finish: the request passes the front stage register and the queue, then the back
//   half enters its emit state, later while it is busy, and registers each result;
//   one result per cycle while rsp_tready stays high
// reset clears the pool count, the running distance and sets the keep limit
//   to 16; the query words hold no value until loaded
// a stalled rsp side holds the back half, the queue fills, then req_tready drops
module hamming_top_k_shortlist_core
   import hsl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // word[63:0], word_index[65:64], doc_id[105:66], doc_present[106],
   // doc_deleted[107], zero pad[111:108]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [KIND_W-1:0]      req_tuser,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // slot_doc_id[39:0], slot_distance[48:40], pool_count[53:49], zero pad[55:54]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // empty_res[0]
   output logic                   rsp_tuser,
   output logic                   rsp_tlast,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [CNT_W-1:0] keep_limit_ff, keep_limit_in;
   logic             csr_hit;
   logic             csr_wr;

   hsl_cmd_type      push_data;
   hsl_cmd_type      pop_data;
   logic             push;
   logic             pop;
   logic             full;
   logic             empty;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == CSR_KEEP_LIMIT);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(keep_limit_ff) : '0;

   assign keep_limit_in = csr_wr ? csr_pwdata[CNT_W-1:0] : keep_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_limit_ff <= CNT_W'(KEEP_LIMIT_RESET);
      end else begin
         keep_limit_ff <= keep_limit_in;
      end
   end

   hsl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_push     (push),
      .q_data     (push_data),
      .q_full     (full)
   );

   hsl_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   hsl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .keep_limit (keep_limit_ff),
      .q_empty    (empty),
      .q_data     (pop_data),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
